// File: rtl/bsfb_pkg.sv
// Shared types and constants for the byte-stuffing frame builder.
package bsfb_pkg;

    localparam logic [7:0] START_BYTE = 8'hFF;
    localparam logic [7:0] STUFF_BYTE = 8'hFE;

    // One bit for each byte an input word can cause, in line order.
    typedef logic [4:0] t_mask;

    localparam t_mask M_START = 5'b00001;
    localparam t_mask M_LEN   = 5'b00010;
    localparam t_mask M_DATA  = 5'b00100;
    localparam t_mask M_STUFF = 5'b01000;
    localparam t_mask M_CHK   = 5'b10000;

    // Everything the byte sequencer needs to emit the bytes of one input word.
    typedef struct packed {
        t_mask      mask;
        logic [7:0] data;
        logic [7:0] len;
        logic [7:0] check;
    } t_plan;

endpackage

// File: rtl/bsfb_intf.sv
// Handshake channels of the frame builder: payload words in, line bytes out.
interface bsfb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       last_byte;

    modport source (output valid, output payload_byte, output last_byte, input ready);
    modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

interface bsfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_end;
    logic       frame_end;

    modport source (output valid, output out_byte, output run_end, output frame_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_end, input frame_end,
                    output ready);
endinterface

// File: rtl/bsfb_frame_ctl.sv
// Frame state, length register and per-word byte plan with checksum.
module bsfb_frame_ctl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [7:0]     i_cfg_wdata,
    input  logic           i_accept,
    input  logic [7:0]     i_payload_byte,
    input  logic           i_last_byte,
    output bsfb_pkg::t_plan o_plan
);
    import bsfb_pkg::*;

    logic       r_in_frame;
    logic [7:0] r_sum;
    logic [7:0] r_frame_length;
    logic       n_in_frame;
    logic [7:0] n_sum;
    logic       w_hdr;
    logic [7:0] w_base;
    logic [7:0] w_total;

    always_comb begin
        w_hdr   = !r_in_frame;
        w_base  = w_hdr ? r_frame_length : r_sum;
        w_total = w_base + i_payload_byte;

        o_plan.mask  = {i_last_byte, (i_payload_byte == START_BYTE), 1'b1, w_hdr, w_hdr};
        o_plan.data  = i_payload_byte;
        o_plan.len   = r_frame_length;
        o_plan.check = 8'(9'h100 - {1'b0, w_total});

        // close the frame on the last word, else keep summing
        n_in_frame = !i_last_byte;
        n_sum      = i_last_byte ? 8'h00 : w_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame     <= 1'b0;
            r_sum          <= 8'h00;
            r_frame_length <= 8'h00;
        end else begin
            if (i_cfg_we) begin
                r_frame_length <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_in_frame <= n_in_frame;
                r_sum      <= n_sum;
            end
        end
    end

endmodule

// File: rtl/bsfb_byte_seq.sv
// Pending-byte and output registers: one line byte a cycle unless the output stalls.
module bsfb_byte_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bsfb_pkg::t_plan i_plan,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_run_end,
    output logic            o_frame_end
);
    import bsfb_pkg::*;

    t_mask      r_mask;
    logic [7:0] r_data;
    logic [7:0] r_len;
    logic [7:0] r_check;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_run_end;
    logic       r_frame_end;

    t_mask      w_low;
    t_mask      w_rest;
    logic       w_load;
    logic       w_accept;
    logic [7:0] n_out_byte;

    always_comb begin
        w_low    = r_mask & (~r_mask + 5'd1);
        w_rest   = r_mask & ~w_low;
        w_load   = (r_mask != '0) && (!r_out_valid || i_out_ready);
        // take a new word once the held one has gone or sends its final byte now
        o_in_ready = (r_mask == '0) || (w_load && (w_rest == '0));
        w_accept   = i_in_valid && o_in_ready;

        case (w_low)
            M_START: n_out_byte = START_BYTE;
            M_LEN:   n_out_byte = r_len;
            M_STUFF: n_out_byte = STUFF_BYTE;
            M_CHK:   n_out_byte = r_check;
            default: n_out_byte = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_mask <= i_plan.mask;
            end else if (w_load) begin
                r_mask <= w_rest;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data  <= i_plan.data;
            r_len   <= i_plan.len;
            r_check <= i_plan.check;
        end
        if (w_load) begin
            r_out_byte  <= n_out_byte;
            r_run_end   <= (w_rest == '0);
            r_frame_end <= (w_low == M_CHK);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_end   = r_run_end;
    assign o_frame_end = r_frame_end;

    a_chk_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_frame_end |-> r_run_end)
        else $error("checksum byte not marked as end of run");

    a_accept_loads_plan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_mask == $past(i_plan.mask))
        else $error("accepted word plan not held");

    a_load_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_out_valid)
        else $error("loaded byte not presented");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mask == '0) |-> o_in_ready)
        else $error("idle sequencer refuses input");

endmodule

// File: rtl/byte_stuffing_frame_builder.sv
// Top level of the byte-stuffing frame builder with checksum.
// Payload words (a byte and a last-of-frame flag) go in on i_in; line bytes come
// out on o_out. The first word of a frame yields the start byte 0xFF and the
// length byte from the frame_length register ahead of the payload byte; a
// payload byte of 0xFF is followed by a stuffing byte 0xFE; the last word is
// followed by the checksum, the two's complement of length plus payload bytes,
// flagged by frame_end. run_end marks the final byte caused by each word. One
// input word causes 1 to 5 line bytes; the output register sends one byte a
// cycle when o_out.ready allows, and with that a plain payload word streams at
// one word a cycle. A new word is taken in the same cycle the last byte of the
// previous one moves to the output register. frame_length is sampled when a
// frame opens; write it through i_cfg_we/i_cfg_wdata while the block is idle.
module byte_stuffing_frame_builder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    bsfb_in_if.sink           i_in,
    bsfb_out_if.source        o_out
);
    import bsfb_pkg::*;

    t_plan w_plan;
    logic  w_in_ready;
    logic  w_accept;

    // a word is taken when the sequencer can hold it
    assign w_accept   = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;

    // frame state and checksum, planned as the word is taken
    bsfb_frame_ctl u_ctl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_accept       (w_accept),
        .i_payload_byte (i_in.payload_byte),
        .i_last_byte    (i_in.last_byte),
        .o_plan         (w_plan)
    );

    // drain the planned bytes one a cycle to the output register unless stalled
    bsfb_byte_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_plan      (w_plan),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_byte  (o_out.out_byte),
        .o_run_end   (o_out.run_end),
        .o_frame_end (o_out.frame_end)
    );

endmodule
